// ----- rtl/int4_dequant_dot_product_macros.svh -----
// Assertion macros shared by the int4 dequantizing dot product RTL.
`ifndef INT4_DEQUANT_DOT_PRODUCT_MACROS_SVH
`define INT4_DEQUANT_DOT_PRODUCT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DQ_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DQ_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DQ_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons)
`define DQ_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons)
`endif
`endif

// ----- rtl/int4dq_pkg.sv -----
// Types, constants and float conversion functions for the int4 dequantizing dot product.
package int4dq_pkg;

    localparam int NIBBLES       = 8;
    localparam int NIB_W         = 4;
    localparam int LANE_W        = 3;
    localparam int LANES_DEFAULT = 8;

    typedef enum logic [1:0] {
        STEP_SUB  = 2'd0,
        STEP_MULS = 2'd1,
        STEP_MULA = 2'd2,
        STEP_ACC  = 2'd3
    } step_t;

    typedef struct packed {
        logic              load;
        logic              run_a;
        logic              run_b;
        step_t             step;
        logic [LANE_W-1:0] lane;
        logic              finish;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } status_t;

    function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
        logic       s;
        logic [4:0] e;
        logic [9:0] m;
        logic [3:0] p;
        logic [9:0] mn;
        logic [31:0] r;
        begin
            s = h[15];
            e = h[14:10];
            m = h[9:0];
            p = 4'd0;
            for (int i = 0; i < 10; i++) begin
                if (m[i]) p = 4'(i);
            end
            mn = m << (4'd10 - p);
            if (e == 5'd0) begin
                if (m == 10'd0) r = {s, 31'd0};
                else r = {s, 8'd103 + {4'd0, p}, mn, 13'd0};
            end else if (e == 5'd31) begin
                if (m == 10'd0) r = {s, 8'hFF, 23'd0};
                else r = {s, 8'hFF, 23'h400000 | {m, 13'd0}};
            end else begin
                r = {s, {3'd0, e} + 8'd112, m, 13'd0};
            end
            return r;
        end
    endfunction

    function automatic logic [31:0] nib_to_f32(input logic [NIB_W-1:0] q);
        logic [2:0]  p;
        logic [22:0] t;
        logic [31:0] r;
        begin
            p = 3'd0;
            for (int i = 0; i < NIB_W; i++) begin
                if (q[i]) p = 3'(i);
            end
            t = {q, 19'd0};
            if (q == '0) r = 32'd0;
            else r = {1'b0, 8'd127 + {5'd0, p}, t << (3'd4 - p)};
            return r;
        end
    endfunction

    function automatic logic [15:0] f32_to_f16(input logic [31:0] u);
        logic        s;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [7:0]  shift;
        logic [23:0] m;
        logic [23:0] q;
        logic [23:0] rem;
        logic [23:0] half;
        logic [15:0] h;
        logic [12:0] rem13;
        logic [15:0] r;
        begin
            s     = u[31];
            ex    = u[30:23];
            man   = u[22:0];
            shift = 8'd126 - ex;
            m     = {1'b1, man};
            q     = m >> shift[4:0];
            rem   = m & ~({24{1'b1}} << shift[4:0]);
            half  = 24'd1 << (shift[4:0] - 5'd1);
            h     = {s, ex[4:0] - 5'd16, man[22:13]};
            rem13 = man[12:0];
            if (ex == 8'd255) begin
                r = (man != 23'd0) ? 16'h7E00 : {s, 15'h7C00};
            end else if (ex >= 8'd143) begin
                r = {s, 15'h7C00};
            end else if (ex <= 8'd112) begin
                if (ex == 8'd0 || shift >= 8'd25) begin
                    r = {s, 15'd0};
                end else begin
                    if (rem > half || (rem == half && q[0])) q = q + 24'd1;
                    r = {s, q[14:0]};
                end
            end else begin
                if (rem13 > 13'h1000 || (rem13 == 13'h1000 && h[0])) h = h + 16'd1;
                r = h;
            end
            return r;
        end
    endfunction

endpackage

// ----- rtl/int4_dequant_dot_product.sv -----
// Top level of the int4 dequantizing dot product: sequencer plus datapath.
//
// Input channel (in_valid/in_stall): one transfer carries a 32-bit word of eight
// 4-bit weights, eight fp16 activations, the group's fp16 scale and zero point,
// and is_last. Output channel (out_valid/out_stall): one fp16 dot_result per
// transfer whose is_last was set.
// Each nibble takes four fp32 operations (subtract zero, times scale, times
// activation, add to accumulator) on one shared float unit, each in two phases:
// phase A multiplies or aligns and adds, phase B normalizes and rounds. An item
// thus holds the input side from its transfer through all its nibbles and the
// finish state, and a result appears in the cycle after that.
// The output register lets the next item be taken and worked on while a result
// waits; only a second result stalls, in the finish state, until the first leaves.
// Reset clears the accumulator to +0 and drops any pending result.
module int4_dequant_dot_product
    import int4dq_pkg::*;
#(
    parameter int LANES = LANES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] packed_word,
    input  logic [15:0] act_0,
    input  logic [15:0] act_1,
    input  logic [15:0] act_2,
    input  logic [15:0] act_3,
    input  logic [15:0] act_4,
    input  logic [15:0] act_5,
    input  logic [15:0] act_6,
    input  logic [15:0] act_7,
    input  logic [15:0] group_scale,
    input  logic [15:0] zero_point,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] dot_result
);

    cmd_t    cmd;
    status_t status;

    int4dq_ctrl #(
        .LANES (LANES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    int4dq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .packed_word (packed_word),
        .act_0       (act_0),
        .act_1       (act_1),
        .act_2       (act_2),
        .act_3       (act_3),
        .act_4       (act_4),
        .act_5       (act_5),
        .act_6       (act_6),
        .act_7       (act_7),
        .group_scale (group_scale),
        .zero_point  (zero_point),
        .is_last     (is_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .dot_result  (dot_result)
    );

endmodule

// ----- rtl/int4dq_ctrl.sv -----
// Sequencer that steps the shared float unit through the four operations of every nibble.
`include "int4_dequant_dot_product_macros.svh"
module int4dq_ctrl
    import int4dq_pkg::*;
#(
    parameter int LANES = LANES_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_OPA  = 4'b0010,
        S_OPB  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    step_t             step_reg, step_next;
    logic [LANE_W-1:0] lane_reg, lane_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= STEP_SUB;
            lane_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            lane_reg  <= lane_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        lane_next  = lane_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        cmd.lane   = lane_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = STEP_SUB;
                    lane_next  = '0;
                    state_next = S_OPA;
                end
            end
            S_OPA:
            begin
                cmd.run_a  = 1'b1;
                state_next = S_OPB;
            end
            S_OPB:
            begin
                cmd.run_b  = 1'b1;
                state_next = S_OPA;
                case (step_reg)
                    STEP_SUB:  step_next = STEP_MULS;
                    STEP_MULS: step_next = STEP_MULA;
                    STEP_MULA: step_next = STEP_ACC;
                    default:
                    begin
                        step_next = STEP_SUB;
                        if (lane_reg == LANE_W'(LANES - 1)) state_next = S_FIN;
                        else lane_next = lane_reg + 1'b1;
                    end
                endcase
            end
            S_FIN:
            begin
                // A result waits here until the output register can take it.
                if (!status.last || status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    `DQ_ASSERT_NEXT(a_then_b, clk, rst_n, cmd.run_a, cmd.run_b)
    `DQ_ASSERT_NEXT(busy_after_transfer, clk, rst_n, in_valid && !in_stall, in_stall)
    `DQ_ASSERT_IMPL(lane_bound, clk, rst_n, state_reg != S_IDLE, lane_reg <= LANE_W'(LANES - 1))

endmodule

// ----- rtl/int4dq_datapath.sv -----
// Operand registers, two-phase fp32 add/multiply unit, accumulator and output register.
module int4dq_datapath
    import int4dq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [31:0] packed_word,
    input  logic [15:0] act_0,
    input  logic [15:0] act_1,
    input  logic [15:0] act_2,
    input  logic [15:0] act_3,
    input  logic [15:0] act_4,
    input  logic [15:0] act_5,
    input  logic [15:0] act_6,
    input  logic [15:0] act_7,
    input  logic [15:0] group_scale,
    input  logic [15:0] zero_point,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] dot_result
);

    logic [31:0] word_reg;
    logic [31:0] act_reg [NIBBLES];
    logic [31:0] scale_reg;
    logic [31:0] zero_reg;
    logic        last_reg;
    logic [31:0] t_reg;
    logic [31:0] acc_reg;
    logic        out_valid_reg;
    logic [15:0] dot_result_reg;

    // Registered raw result between the two phases.
    logic               ra_sign_reg;
    logic signed [10:0] ra_exp_reg;
    logic [49:0]        ra_x_reg;
    logic               ra_spec_reg;
    logic [31:0]        ra_spec_val_reg;

    logic [31:0] opa, opb;
    logic        is_mul;

    always_comb
    begin
        opa    = t_reg;
        opb    = scale_reg;
        is_mul = 1'b1;
        case (cmd.step)
            STEP_SUB:
            begin
                opa    = nib_to_f32(word_reg[{cmd.lane, 2'b00} +: NIB_W]);
                opb    = {~zero_reg[31], zero_reg[30:0]};
                is_mul = 1'b0;
            end
            STEP_MULS:
            begin
                opa = t_reg;
                opb = scale_reg;
            end
            STEP_MULA:
            begin
                opa = t_reg;
                opb = act_reg[cmd.lane];
            end
            default:
            begin
                opa    = acc_reg;
                opb    = t_reg;
                is_mul = 1'b0;
            end
        endcase
    end

    // Phase A: unpack, multiply or align and add.
    logic        sa, sb;
    logic [7:0]  efa, efb, ea, eb;
    logic [23:0] ma, mb;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [47:0] prod;
    logic        a_big;
    logic [7:0]  ebig, d;
    logic [23:0] mbig, msml;
    logic [49:0] xbig, xsml0, xsml, xsum;
    logic        sbig, eff_sub;
    logic               pa_sign;
    logic signed [10:0] pa_exp;
    logic [49:0]        pa_x;
    logic               pa_spec;
    logic [31:0]        pa_spec_val;

    always_comb
    begin
        sa     = opa[31];
        sb     = opb[31];
        efa    = opa[30:23];
        efb    = opb[30:23];
        ea     = (efa == 8'd0) ? 8'd1 : efa;
        eb     = (efb == 8'd0) ? 8'd1 : efb;
        ma     = {efa != 8'd0, opa[22:0]};
        mb     = {efb != 8'd0, opb[22:0]};
        nan_a  = (efa == 8'hFF) && (opa[22:0] != 23'd0);
        nan_b  = (efb == 8'hFF) && (opb[22:0] != 23'd0);
        inf_a  = (efa == 8'hFF) && (opa[22:0] == 23'd0);
        inf_b  = (efb == 8'hFF) && (opb[22:0] == 23'd0);
        zero_a = (efa == 8'd0) && (opa[22:0] == 23'd0);
        zero_b = (efb == 8'd0) && (opb[22:0] == 23'd0);

        prod = ma * mb;

        a_big   = {ea, ma} >= {eb, mb};
        ebig    = a_big ? ea : eb;
        d       = a_big ? (ea - eb) : (eb - ea);
        mbig    = a_big ? ma : mb;
        msml    = a_big ? mb : ma;
        sbig    = a_big ? sa : sb;
        eff_sub = sa ^ sb;
        xbig    = {1'b0, mbig, 25'd0};
        xsml0   = {1'b0, msml, 25'd0};
        if (d >= 8'd50) xsml = {49'd0, |msml};
        else xsml = (xsml0 >> d) | {49'd0, |(xsml0 & ~({50{1'b1}} << d))};
        xsum = eff_sub ? (xbig - xsml) : (xbig + xsml);

        if (is_mul)
        begin
            pa_sign     = sa ^ sb;
            pa_exp      = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126;
            pa_x        = {1'b0, prod, 1'b0};
            pa_spec     = nan_a | nan_b | inf_a | inf_b;
            if (nan_a | nan_b | (inf_a & zero_b) | (zero_a & inf_b))
                pa_spec_val = 32'h7FC00000;
            else
                pa_spec_val = {sa ^ sb, 8'hFF, 23'd0};
        end
        else
        begin
            // An exact cancellation gives +0 unless both operands are negative.
            pa_sign     = (xsum == 50'd0) ? (sa & sb) : sbig;
            pa_exp      = $signed({3'd0, ebig});
            pa_x        = xsum;
            pa_spec     = nan_a | nan_b | inf_a | inf_b;
            if (nan_a | nan_b | (inf_a & inf_b & eff_sub))
                pa_spec_val = 32'h7FC00000;
            else
                pa_spec_val = {inf_a ? sa : sb, 8'hFF, 23'd0};
        end
    end

    // Phase B: normalize, handle subnormals, round to nearest even.
    logic [5:0]         lead, lz;
    logic [49:0]        xn;
    logic signed [10:0] e1;
    logic [10:0]        sh;
    logic [26:0]        m27, ms;
    logic [7:0]         efield;
    logic               inc;
    logic [30:0]        body;
    logic [31:0]        res_b;

    always_comb
    begin
        lead = 6'd0;
        for (int i = 0; i < 50; i++)
        begin
            if (ra_x_reg[i]) lead = 6'(i);
        end
        lz  = 6'd49 - lead;
        xn  = ra_x_reg << lz;
        e1  = ra_exp_reg + 11'sd1 - $signed({5'd0, lz});
        m27 = {xn[49:24], |xn[23:0]};
        sh  = 11'(11'sd1 - e1);
        if (e1 <= 11'sd0)
        begin
            efield = 8'd0;
            if (sh >= 11'd27) ms = {26'd0, |m27};
            else ms = (m27 >> sh[4:0]) | {26'd0, |(m27 & ~({27{1'b1}} << sh[4:0]))};
        end
        else
        begin
            efield = e1[7:0];
            ms     = m27;
        end
        inc  = ms[2] & (ms[1] | ms[0] | ms[3]);
        body = {efield, ms[25:3]} + {30'd0, inc};
        if (ra_spec_reg) res_b = ra_spec_val_reg;
        else if (ra_x_reg == 50'd0) res_b = {ra_sign_reg, 31'd0};
        else if (e1 >= 11'sd255) res_b = {ra_sign_reg, 8'hFF, 23'd0};
        else res_b = {ra_sign_reg, body};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg   <= packed_word;
            act_reg[0] <= f16_to_f32(act_0);
            act_reg[1] <= f16_to_f32(act_1);
            act_reg[2] <= f16_to_f32(act_2);
            act_reg[3] <= f16_to_f32(act_3);
            act_reg[4] <= f16_to_f32(act_4);
            act_reg[5] <= f16_to_f32(act_5);
            act_reg[6] <= f16_to_f32(act_6);
            act_reg[7] <= f16_to_f32(act_7);
            scale_reg  <= f16_to_f32(group_scale);
            zero_reg   <= f16_to_f32(zero_point);
            last_reg   <= is_last;
        end
        if (cmd.run_a)
        begin
            ra_sign_reg     <= pa_sign;
            ra_exp_reg      <= pa_exp;
            ra_x_reg        <= pa_x;
            ra_spec_reg     <= pa_spec;
            ra_spec_val_reg <= pa_spec_val;
        end
        if (cmd.run_b && cmd.step != STEP_ACC)
        begin
            t_reg <= res_b;
        end
        if (cmd.finish && last_reg)
        begin
            dot_result_reg <= f32_to_f16(acc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.run_b && cmd.step == STEP_ACC) acc_reg <= res_b;
            else if (cmd.finish && last_reg) acc_reg <= 32'd0;
            if (cmd.finish && last_reg) out_valid_reg <= 1'b1;
            else if (!out_stall) out_valid_reg <= 1'b0;
        end
    end

    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign dot_result      = dot_result_reg;

endmodule
